/* src/int16_tile_matmul_offset_binary_defines.svh */
// Assertion macros used by the port checker file.
`ifndef INT16_TILE_MATMUL_OFFSET_BINARY_DEFINES_SVH
`define INT16_TILE_MATMUL_OFFSET_BINARY_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define ITMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, reset masks the check.
`define ITMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

/* src/itmm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmm_pkg
// Sizes, command codes and pipeline types of the int16 tile matrix multiplier.
// ----------------------------------------------------------------------------
package itmm_pkg;

    localparam int MAX_K_TILES = 8;
    localparam int TILE_DIM    = 32;
    localparam int K_DEPTH     = MAX_K_TILES * TILE_DIM;
    localparam int K_BITS      = $clog2(K_DEPTH);
    localparam int TILE_BITS   = $clog2(TILE_DIM);
    localparam int ADDR_BITS   = TILE_BITS + K_BITS;
    localparam int STORE_DEPTH = TILE_DIM * K_DEPTH;
    localparam int EFF_BITS    = $clog2(MAX_K_TILES + 1);

    typedef enum logic [1:0] {
        CMD_LOAD_ACT = 2'd0,
        CMD_LOAD_WGT = 2'd1,
        CMD_ROW      = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    // register select is paddr[2]
    localparam logic REG_K_TILES = 1'b0;

    typedef struct packed {
        logic                 first;
        logic                 last;
        logic                 zero;
        logic [TILE_BITS-1:0] col;
    } t_step;

endpackage

/* src/int16_tile_matmul_offset_binary.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int16_tile_matmul_offset_binary
// 32x32 output tile of an offset-binary int16 matrix product, int32 sums.
// ----------------------------------------------------------------------------
// Load commands (activation, weight) and unused commands leave busy low. A row
// command keeps busy high until its last result is out; each column takes L steps, where
// L = 32*min(k_tiles, 8), or 1 when the tile count is zero: a single
// multiply-accumulate unit walks every column and every reduction step, one
// product per cycle, behind the registered reads of the two element stores.
// The 32 results come out in column order, one strobe each, the last with
// o_last set; the receiver cannot stall, so every strobe is a transfer.
module int16_tile_matmul_offset_binary
    import itmm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_cmd,
    input  logic [4:0]           i_row,
    input  logic [4:0]           i_col,
    input  logic [11:0]          i_k_index,
    input  logic [15:0]          i_value,
    // result channel
    output logic                 o_strobe,
    output logic signed [31:0]   o_result,
    output logic [4:0]           o_out_col,
    output logic                 o_last,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} t_state;

    t_state                r_state, n_state;
    logic [7:0]            r_k_tiles;
    logic [TILE_BITS-1:0]  r_row;
    logic [K_BITS-1:0]     r_k, n_k;
    logic [TILE_BITS-1:0]  r_j, n_j;
    logic                  r_s1_v, r_s2_v;
    t_step                 r_s1, r_s2, w_step;
    logic signed [31:0]    r_prod, r_acc, w_acc_next;
    logic                  r_strobe, r_last;
    logic signed [31:0]    r_result;
    logic [TILE_BITS-1:0]  r_out_col;

    logic [15:0]           r_act_mem [STORE_DEPTH];
    logic [15:0]           r_wgt_mem [STORE_DEPTH];
    logic [15:0]           r_act_q, r_wgt_q;

    logic                  w_accept, w_in_range, w_act_we, w_wgt_we, w_cfg_we;
    logic [EFF_BITS-1:0]   w_eff;
    logic                  w_zero;
    logic [K_BITS:0]       w_klen;
    logic [K_BITS-1:0]     w_k_last;
    logic signed [15:0]    w_a, w_w;

    assign w_accept   = start && !busy;
    assign w_in_range = i_k_index < 12'(K_DEPTH);
    assign w_act_we   = w_accept && (t_cmd'(i_cmd) == CMD_LOAD_ACT) && w_in_range;
    assign w_wgt_we   = w_accept && (t_cmd'(i_cmd) == CMD_LOAD_WGT) && w_in_range;
    assign w_cfg_we   = psel && penable && pwrite && pready && (paddr[2] == REG_K_TILES);

    // clamp tile count to the built store depth
    assign w_eff    = (r_k_tiles > 8'(MAX_K_TILES)) ? EFF_BITS'(MAX_K_TILES)
                                                    : EFF_BITS'(r_k_tiles);
    assign w_zero   = (w_eff == '0);
    assign w_klen   = (K_BITS+1)'(w_eff) << TILE_BITS;
    assign w_k_last = K_BITS'(w_klen - (K_BITS+1)'(1));

    // element stores: write on load transfers, read every cycle
    always_ff @(posedge i_clk) begin
        if (w_act_we) begin
            r_act_mem[{i_row, i_k_index[K_BITS-1:0]}] <= i_value;
        end
        r_act_q <= r_act_mem[{r_row, r_k}];
    end

    always_ff @(posedge i_clk) begin
        if (w_wgt_we) begin
            r_wgt_mem[{i_k_index[K_BITS-1:0], i_col}] <= i_value;
        end
        r_wgt_q <= r_wgt_mem[{r_k, r_j}];
    end

    // offset binary to two's complement: flip the sign bit
    assign w_a = {~r_act_q[15], r_act_q[14:0]};
    assign w_w = {~r_wgt_q[15], r_wgt_q[14:0]};

    always_comb begin
        w_step.first = (r_k == '0);
        w_step.last  = w_zero || (r_k == w_k_last);
        w_step.zero  = w_zero;
        w_step.col   = r_j;
    end

    assign w_acc_next = (r_s2.first ? 32'sd0 : r_acc) + r_prod;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_j     = r_j;
        unique case (r_state)
            S_IDLE: begin
                n_k = '0;
                n_j = '0;
                if (w_accept && (t_cmd'(i_cmd) == CMD_ROW)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_step.last) begin
                    n_k = '0;
                    if (r_j == TILE_BITS'(TILE_DIM - 1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_j = r_j + TILE_BITS'(1);
                    end
                end else begin
                    n_k = r_k + K_BITS'(1);
                end
            end
            S_DRAIN: begin
                if (r_strobe && r_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k_tiles <= 8'd1;
            r_k       <= '0;
            r_j       <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_j      <= n_j;
            r_s1_v   <= (r_state == S_RUN);
            r_s2_v   <= r_s1_v;
            r_strobe <= r_s2_v && r_s2.last;
            if (w_cfg_we) begin
                r_k_tiles <= pwdata[7:0];
            end
        end
        // payload, no reset needed
        if (w_accept) begin
            r_row <= i_row;
        end
        r_s1   <= w_step;
        r_s2   <= r_s1;
        r_prod <= r_s1.zero ? 32'sd0 : 32'(w_a * w_w);
        if (r_s2_v) begin
            r_acc <= w_acc_next;
            if (r_s2.last) begin
                r_result  <= w_acc_next;
                r_out_col <= r_s2.col;
                r_last    <= (r_s2.col == TILE_BITS'(TILE_DIM - 1));
            end
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign o_strobe  = r_strobe;
    assign o_result  = r_result;
    assign o_out_col = r_out_col;
    assign o_last    = r_last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_K_TILES) ? {24'd0, r_k_tiles} : 32'd0;

endmodule

/* src/itmm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmm_checker
// Port-level checks of the tile multiplier, bound to the top level.
// ----------------------------------------------------------------------------
`include "int16_tile_matmul_offset_binary_defines.svh"

module itmm_checker
    import itmm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_cmd,
    input logic       o_strobe,
    input logic [4:0] o_out_col,
    input logic       o_last
);

    // results only come during a row command
    `ITMM_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy)

    // last flag marks the final column
    `ITMM_ASSERT_IMP(a_last_col, i_clk, i_rst_n, o_strobe,
        o_last == (o_out_col == 5'(TILE_DIM - 1)))

    // the final result ends the row command
    `ITMM_ASSERT_NXT(a_last_done, i_clk, i_rst_n, o_strobe && o_last, !busy)

    // loads and unused commands finish in the transfer cycle
    `ITMM_ASSERT_NXT(a_load_fast, i_clk, i_rst_n,
        start && !busy && (i_cmd != CMD_ROW), !busy && !o_strobe)

    // a row command starts the sequencer
    `ITMM_ASSERT_NXT(a_row_busy, i_clk, i_rst_n,
        start && !busy && (i_cmd == CMD_ROW), busy)

endmodule

bind int16_tile_matmul_offset_binary itmm_checker u_itmm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_cmd     (i_cmd),
    .o_strobe  (o_strobe),
    .o_out_col (o_out_col),
    .o_last    (o_last)
);

/* tb/sv/int16_tile_matmul_offset_binary_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int16_tile_matmul_offset_binary_tb
// Self-checking bench for the int16 tile matrix multiplier. Both element
// stores are filled first, so no row ever reads an unwritten entry. A short
// directed pass follows, then random load/row traffic under several tile
// counts. Every row request is predicted from shadow copies of the stores.
// The 32 column sums are checked, in order, against the result strobes.
// ----------------------------------------------------------------------------
module int16_tile_matmul_offset_binary_tb;
    import itmm_pkg::*;

    localparam int CLK_HIGH     = 6;
    localparam int CLK_LOW      = 6;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 40;
    localparam int OFFSET_BIAS  = 32768;
    localparam logic [2:0] K_TILES_ADDR = {REG_K_TILES, 2'b00};

    typedef struct {
        t_cmd        cmd;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [11:0] k_index;
        logic [15:0] value;
    } mm_cmd_t;

    typedef struct {
        logic signed [31:0] total;
        logic [4:0]         col;
        logic               last;
    } col_sum_t;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    logic [1:0]         i_cmd     = '0;
    logic [4:0]         i_row     = '0;
    logic [4:0]         i_col     = '0;
    logic [11:0]        i_k_index = '0;
    logic [15:0]        i_value   = '0;
    logic               o_strobe;
    logic signed [31:0] o_result;
    logic [4:0]         o_out_col;
    logic               o_last;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [2:0]         paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    int16_tile_matmul_offset_binary dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_cmd     (i_cmd),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_k_index (i_k_index),
        .i_value   (i_value),
        .o_strobe  (o_strobe),
        .o_result  (o_result),
        .o_out_col (o_out_col),
        .o_last    (o_last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    // shadow state of the block
    logic [15:0] act_shadow [TILE_DIM][K_DEPTH];
    logic [15:0] wgt_shadow [K_DEPTH][TILE_DIM];
    logic [7:0]  k_tiles_shadow = 8'd1;

    mm_cmd_t  pending_cmds  [$];
    col_sum_t expected_sums [$];
    mm_cmd_t  on_pins;
    int       idle_pct   = 0;
    int       err_count  = 0;
    int       cycle_count = 0;

    task automatic flag_mismatch(input string msg);
        if (err_count < MAX_REPORTS) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        err_count++;
    endtask

    function automatic int tiles_in_use(input logic [7:0] k_tiles);
        return (k_tiles > MAX_K_TILES) ? MAX_K_TILES : int'(k_tiles);
    endfunction

    function automatic void predict_row_sums(input logic [4:0] r);
        int          klen;
        int          a;
        int          w;
        logic [31:0] acc;
        klen = tiles_in_use(k_tiles_shadow) * TILE_DIM;
        for (int j = 0; j < TILE_DIM; j++) begin
            acc = '0;
            for (int k = 0; k < klen; k++) begin
                a = int'(act_shadow[r][k]) - OFFSET_BIAS;
                w = int'(wgt_shadow[k][j]) - OFFSET_BIAS;
                acc += a * w;
            end
            expected_sums.push_back('{total: acc, col: j[4:0], last: (j == TILE_DIM - 1)});
        end
    endfunction

    function automatic void apply_cmd(input mm_cmd_t c);
        case (c.cmd)
            CMD_LOAD_ACT: begin
                if (c.k_index < K_DEPTH) act_shadow[c.row][c.k_index] = c.value;
            end
            CMD_LOAD_WGT: begin
                if (c.k_index < K_DEPTH) wgt_shadow[c.k_index][c.col] = c.value;
            end
            CMD_ROW: begin
                predict_row_sums(c.row);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_cmd(input t_cmd cmd, input logic [4:0] row,
                                      input logic [4:0] col, input logic [11:0] k,
                                      input logic [15:0] value);
        pending_cmds.push_back('{cmd: cmd, row: row, col: col, k_index: k, value: value});
    endfunction

    function automatic logic [15:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) return 16'h0000;
        if (roll < 10) return 16'hFFFF;
        return 16'($urandom_range(65535));
    endfunction

    // counts is low for items the block drops (out-of-range loads, unused cmd)
    function automatic void make_random(output mm_cmd_t c, output bit counts, input int klen);
        int roll;
        roll = $urandom_range(99);
        c.row     = 5'($urandom_range(TILE_DIM - 1));
        c.col     = 5'($urandom_range(TILE_DIM - 1));
        c.value   = pick_value();
        c.k_index = ($urandom_range(9) < 8) ? 12'($urandom_range(klen - 1))
                                            : 12'($urandom_range(K_DEPTH - 1));
        counts = 1'b1;
        if (roll < 45) begin
            c.cmd = CMD_LOAD_ACT;
        end else if (roll < 80) begin
            c.cmd = CMD_LOAD_WGT;
        end else if (roll < 90) begin
            c.cmd = CMD_ROW;
        end else if (roll < 95) begin
            c.cmd     = roll[0] ? CMD_LOAD_WGT : CMD_LOAD_ACT;
            c.k_index = 12'($urandom_range(4095, K_DEPTH));
            counts    = 1'b0;
        end else begin
            c.cmd     = CMD_NOP;
            c.k_index = 12'($urandom_range(4095));
            counts    = 1'b0;
        end
    endfunction

    // command driver: start held until the transfer, next item may follow at once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) apply_cmd(on_pins);
            if (!(start && busy)) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    on_pins = pending_cmds.pop_front();
                    start     <= 1'b1;
                    i_cmd     <= on_pins.cmd;
                    i_row     <= on_pins.row;
                    i_col     <= on_pins.col;
                    i_k_index <= on_pins.k_index;
                    i_value   <= on_pins.value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_mon
        col_sum_t want;
        if (i_rst_n && o_strobe) begin
            if (expected_sums.size() == 0) begin
                flag_mismatch($sformatf("result with none pending: col %0d sum %0d",
                                        o_out_col, o_result));
            end else begin
                want = expected_sums.pop_front();
                if (o_result !== want.total)
                    flag_mismatch($sformatf("col %0d sum %0d, want %0d",
                                            want.col, o_result, want.total));
                if (o_out_col !== want.col)
                    flag_mismatch($sformatf("out_col %0d, want %0d", o_out_col, want.col));
                if (o_last !== want.last)
                    flag_mismatch($sformatf("col %0d last %0b, want %0b",
                                            want.col, o_last, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_k_tiles(input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= K_TILES_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        k_tiles_shadow = data[7:0];
    endtask

    // sender stops until every sum is back and the block has gone idle
    task automatic wait_quiet();
        while (pending_cmds.size() != 0 || start || expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input logic [31:0] k_data, input int idle,
                                    input int n_items);
        mm_cmd_t c;
        bit      counts;
        int      counted;
        int      klen;
        write_k_tiles(k_data);
        idle_pct = idle;
        klen = tiles_in_use(k_data[7:0]) * TILE_DIM;
        counted = 0;
        while (counted < n_items) begin
            make_random(c, counts, klen);
            pending_cmds.push_back(c);
            if (counts) counted++;
        end
        wait_quiet();
    endtask

    initial begin : stimulus
        logic [15:0] v;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill both stores; rows 30/31 and columns 30/31 hold the extremes
        idle_pct = 0;
        for (int r = 0; r < TILE_DIM; r++) begin
            for (int k = 0; k < K_DEPTH; k++) begin
                v = (r == 31) ? 16'h0000 : (r == 30) ? 16'hFFFF : pick_value();
                queue_cmd(CMD_LOAD_ACT, 5'(r), 5'($urandom_range(31)), 12'(k), v);
            end
        end
        for (int k = 0; k < K_DEPTH; k++) begin
            for (int j = 0; j < TILE_DIM; j++) begin
                v = (j == 31) ? 16'h0000 : (j == 30) ? 16'hFFFF : pick_value();
                queue_cmd(CMD_LOAD_WGT, 5'($urandom_range(31)), 5'(j), 12'(k), v);
            end
        end
        wait_quiet();

        // directed, reset tile count
        idle_pct = 12;
        queue_cmd(CMD_ROW,      5'd0,  5'd0,  12'd0,    16'h0000);
        queue_cmd(CMD_ROW,      5'd31, 5'd31, 12'd4095, 16'hFFFF);
        queue_cmd(CMD_ROW,      5'd30, 5'd0,  12'd0,    16'h0000);
        queue_cmd(CMD_NOP,      5'd31, 5'd31, 12'd4095, 16'hFFFF);
        queue_cmd(CMD_LOAD_ACT, 5'd31, 5'd0,  12'd4095, 16'hFFFF);
        queue_cmd(CMD_LOAD_WGT, 5'd0,  5'd31, 12'd256,  16'hFFFF);
        queue_cmd(CMD_LOAD_ACT, 5'd0,  5'd0,  12'd0,    16'h8000);
        queue_cmd(CMD_LOAD_WGT, 5'd0,  5'd0,  12'd31,   16'hFFFF);
        queue_cmd(CMD_LOAD_ACT, 5'd0,  5'd0,  12'd31,   16'h0000);
        queue_cmd(CMD_ROW,      5'd0,  5'd0,  12'd0,    16'h0000);
        queue_cmd(CMD_ROW,      5'd31, 5'd0,  12'd0,    16'h0000);
        queue_cmd(CMD_LOAD_ACT, 5'd5,  5'd0,  12'd255,  16'h0001);
        wait_quiet();

        // zero tiles: empty sums
        write_k_tiles(32'd0);
        queue_cmd(CMD_ROW, 5'd5, 5'd0, 12'd0, 16'h0000);
        wait_quiet();

        // above the built maximum: clamped, wraps on the extreme rows
        write_k_tiles(32'd255);
        queue_cmd(CMD_ROW, 5'd31, 5'd0, 12'd0, 16'h0000);
        queue_cmd(CMD_ROW, 5'd5,  5'd0, 12'd0, 16'h0000);
        wait_quiet();
        write_k_tiles(32'd128);
        queue_cmd(CMD_ROW, 5'd30, 5'd0, 12'd0, 16'h0000);
        wait_quiet();

        // random traffic; upper data bits of the first write are ignored
        run_random_phase(32'hFFFF_FF02, 53, 50);
        run_random_phase(32'd1,          0, 40);
        run_random_phase(32'd3,         12, 40);
        run_random_phase(32'd8,         53, 12);

        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/itmm_pkg.sv
src/int16_tile_matmul_offset_binary.sv
src/itmm_checker.sv
tb/sv/int16_tile_matmul_offset_binary_tb.sv
